FILE: rtl/upeq_pkg.sv
// upeq_pkg: shared types, constants and the ordering function for the
// updatable priority event queue. No dependencies.
`timescale 1ns / 1ps

package upeq_pkg;

    localparam int CAPACITY = 256;
    localparam int ID_W     = 30;
    localparam int PRI_W    = 30;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHIFT,
        OP_UPDATE
    } op_t;

    typedef struct packed {
        logic             valid;
        logic [PRI_W-1:0] pri;
        logic [ID_W-1:0]  id;
    } entry_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        op_t              op;
        logic [ID_W-1:0]  find_id;
        logic [ID_W-1:0]  new_id;
        logic [PRI_W-1:0] new_pri;
        logic             hit;
        logic [PRI_W-1:0] old_pri;
    } cmd_t;

    // What a cell hands to its neighbors.
    typedef struct packed {
        entry_t ent;
        logic   after;  // cell sits at or behind the entry being removed
        logic   bnew;   // cell's entry is polled before the new one
    } link_t;

    // True if key a is polled before key b.
    function automatic logic beats(input logic [PRI_W-1:0] a_pri,
                                   input logic [ID_W-1:0]  a_id,
                                   input logic [PRI_W-1:0] b_pri,
                                   input logic [ID_W-1:0]  b_id);
        logic r;
        if (a_pri != b_pri) begin
            r = (a_pri > b_pri);
        end else begin
            r = (a_id < b_id);
        end
        return r;
    endfunction

endpackage

FILE: rtl/upeq_cell.sv
// upeq_cell: one slot of the sorted event chain. Uses upeq_pkg.
// Holds one entry; shifts, holds or takes a neighbor's / the new entry.
`timescale 1ns / 1ps

module upeq_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  upeq_pkg::cmd_t   cmd,
    input  upeq_pkg::link_t  left_link,
    input  upeq_pkg::link_t  right_link,
    output upeq_pkg::link_t  link_out,
    output logic             hit,
    output logic [upeq_pkg::PRI_W-1:0] hit_pri
);

    logic                         valid_reg, valid_next;
    logic [upeq_pkg::PRI_W-1:0]   pri_reg, pri_next;
    logic [upeq_pkg::ID_W-1:0]    id_reg, id_next;

    upeq_pkg::entry_t ent, shrunk_self, shrunk_left, nxt;
    logic after, bnew, beat_self, beat_left;

    always_comb begin
        ent.valid = valid_reg;
        ent.pri   = pri_reg;
        ent.id    = id_reg;

        after = cmd.hit && (!valid_reg ||
                !upeq_pkg::beats(pri_reg, id_reg, cmd.old_pri, cmd.new_id));
        bnew  = valid_reg && upeq_pkg::beats(pri_reg, id_reg, cmd.new_pri, cmd.new_id);

        link_out.ent   = ent;
        link_out.after = after;
        link_out.bnew  = bnew;

        hit     = valid_reg && (id_reg == cmd.find_id);
        hit_pri = hit ? pri_reg : '0;

        // Chain with the old entry taken out, seen at this slot and the one before.
        shrunk_self = after ? right_link.ent : ent;
        shrunk_left = left_link.after ? ent : left_link.ent;
        beat_self   = after ? right_link.bnew : bnew;
        beat_left   = left_link.after ? bnew : left_link.bnew;

        nxt = ent;
        case (cmd.op)
            upeq_pkg::OP_SHIFT: begin
                nxt = right_link.ent;
            end
            upeq_pkg::OP_UPDATE: begin
                if (beat_self) begin
                    nxt = shrunk_self;
                end else if (beat_left) begin
                    nxt.valid = 1'b1;
                    nxt.pri   = cmd.new_pri;
                    nxt.id    = cmd.new_id;
                end else begin
                    nxt = shrunk_left;
                end
            end
            default: begin
                nxt = ent;
            end
        endcase

        valid_next = nxt.valid;
        pri_next   = nxt.pri;
        id_next    = nxt.id;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        pri_reg <= pri_next;
        id_reg  <= id_next;
    end

endmodule

FILE: rtl/updatable_priority_event_queue.sv
// updatable_priority_event_queue: top level, request FSM and the cell chain.
// Uses upeq_pkg and upeq_cell.
`timescale 1ns / 1ps

// Holds up to 256 events (id, priority) in a chain of cells kept sorted with
// the next event to poll at the head. Every request passes through the accept
// state (IDLE), in which all cells compare the id in parallel and the matching
// priority is collected, and the APPLY state, in which every cell moves at
// once (shift toward the head on a poll, remove-and-insert on a set). APPLY
// waits while the previous result is still held in the output register, and a
// new request is not accepted until the previous one has been applied. No
// clearing pass is needed after reset.

module updatable_priority_event_queue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [upeq_pkg::ID_W-1:0]       s_event_id,
    input  logic [upeq_pkg::PRI_W-1:0]      s_priority_req,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [upeq_pkg::STATUS_W-1:0]   m_status,
    output logic [upeq_pkg::ID_W-1:0]       m_polled_id
);

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    state_t                         state_reg;
    logic                           req_mode_reg;
    logic [upeq_pkg::ID_W-1:0]      req_id_reg;
    logic [upeq_pkg::PRI_W-1:0]     req_pri_reg;
    logic                           hit_reg;
    logic [upeq_pkg::PRI_W-1:0]     old_pri_reg;
    logic                           m_valid_reg;
    logic [upeq_pkg::STATUS_W-1:0]  m_status_reg;
    logic [upeq_pkg::ID_W-1:0]      m_polled_id_reg;

    upeq_pkg::cmd_t  cmd;
    upeq_pkg::link_t links [upeq_pkg::CAPACITY];
    upeq_pkg::link_t head_tie, tail_tie;
    logic                       cell_hit [upeq_pkg::CAPACITY];
    logic [upeq_pkg::PRI_W-1:0] cell_hit_pri [upeq_pkg::CAPACITY];

    logic                       hit_any;
    logic [upeq_pkg::PRI_W-1:0] hit_pri_any;
    logic                       out_free, accept, full;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign full        = links[upeq_pkg::CAPACITY-1].ent.valid;
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_polled_id = m_polled_id_reg;

    // Chain ends: nothing ahead of the head, an empty slot behind the tail.
    always_comb begin
        head_tie.ent   = '0;
        head_tie.after = 1'b0;
        head_tie.bnew  = 1'b1;
        tail_tie.ent   = '0;
        tail_tie.after = 1'b1;
        tail_tie.bnew  = 1'b0;
    end

    // At most one cell matches an id, so the priorities can be OR-ed.
    always_comb begin
        hit_any     = 1'b0;
        hit_pri_any = '0;
        for (int i = 0; i < upeq_pkg::CAPACITY; i++) begin
            hit_any     = hit_any | cell_hit[i];
            hit_pri_any = hit_pri_any | cell_hit_pri[i];
        end
    end

    always_comb begin
        cmd.op      = upeq_pkg::OP_HOLD;
        cmd.find_id = s_event_id;
        cmd.new_id  = req_id_reg;
        cmd.new_pri = req_pri_reg;
        cmd.hit     = hit_reg;
        cmd.old_pri = old_pri_reg;
        if (state_reg == ST_APPLY && out_free) begin
            if (req_mode_reg == upeq_pkg::MODE_POLL) begin
                cmd.op = upeq_pkg::OP_SHIFT;
            end else if (hit_reg || !full) begin
                cmd.op = upeq_pkg::OP_UPDATE;
            end
        end
    end

    for (genvar g = 0; g < upeq_pkg::CAPACITY; g++) begin : g_cell
        upeq_pkg::link_t left_l, right_l;
        if (g == 0) begin : g_head
            assign left_l = head_tie;
        end else begin : g_mid_l
            assign left_l = links[g-1];
        end
        if (g == upeq_pkg::CAPACITY-1) begin : g_tail
            assign right_l = tail_tie;
        end else begin : g_mid_r
            assign right_l = links[g+1];
        end
        upeq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .left_link  (left_l),
            .right_link (right_l),
            .link_out   (links[g]),
            .hit        (cell_hit[g]),
            .hit_pri    (cell_hit_pri[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_APPLY;
                    end
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                ST_APPLY: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end

        if (accept) begin
            req_mode_reg <= s_mode;
            req_id_reg   <= s_event_id;
            req_pri_reg  <= s_priority_req;
            hit_reg      <= hit_any;
            old_pri_reg  <= hit_pri_any;
        end

        if (state_reg == ST_APPLY && out_free) begin
            if (req_mode_reg == upeq_pkg::MODE_POLL) begin
                if (links[0].ent.valid) begin
                    m_status_reg    <= upeq_pkg::STATUS_OK;
                    m_polled_id_reg <= links[0].ent.id;
                end else begin
                    m_status_reg    <= upeq_pkg::STATUS_EMPTY;
                    m_polled_id_reg <= '0;
                end
            end else begin
                m_polled_id_reg <= '0;
                if (!hit_reg && full) begin
                    m_status_reg <= upeq_pkg::STATUS_FULL;
                end else begin
                    m_status_reg <= upeq_pkg::STATUS_OK;
                end
            end
        end
    end

endmodule

FILE: bench/tb_top.sv
// tb_top: self-checking bench for updatable_priority_event_queue.
// A directed table, then random set/poll requests, checked against an
// in-bench predictor. Depends on upeq_pkg and the RTL top only.
`timescale 1ns / 1ps

module tb_top;
    import upeq_pkg::*;

    localparam int RAND_PER_PHASE = 340;
    localparam int FILL_LEN       = 290;   // set-heavy part of each phase, then drain
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int PRINT_LIMIT    = 40;

    localparam logic [ID_W-1:0]  ID_MAX      = '1;
    localparam logic [PRI_W-1:0] PRI_MAX     = '1;
    localparam logic [PRI_W-1:0] PRI_BILLION = 30'd1000000000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     polled_id;
    } outcome_t;

    typedef struct packed {
        logic             mode;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic             typed;    // want holds the answer; otherwise predicted
        outcome_t         want;
    } dir_row_t;

    localparam int DIR_ROWS_N = 26;
    localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
        '{MODE_POLL, 30'd0,        30'd0,        1'b1, '{STATUS_EMPTY, 30'd0}},
        '{MODE_SET,  30'd5,        30'd100,      1'b1, '{STATUS_OK, 30'd0}},
        '{MODE_SET,  ID_MAX,       PRI_MAX,      1'b1, '{STATUS_OK, 30'd0}},
        '{MODE_SET,  30'd0,        PRI_BILLION,  1'b1, '{STATUS_OK, 30'd0}},
        '{MODE_SET,  30'd7,        30'd0,        1'b1, '{STATUS_OK, 30'd0}},
        '{MODE_SET,  30'd9,        30'd100,      1'b1, '{STATUS_OK, 30'd0}},
        // priority above one billion still wins
        '{MODE_POLL, 30'd0,        30'd0,        1'b1, '{STATUS_OK, ID_MAX}},
        // update in place of a held id
        '{MODE_SET,  30'd5,        30'd1000,     1'b1, '{STATUS_OK, 30'd0}},
        '{MODE_POLL, 30'd0,        30'd0,        1'b0, '{STATUS_OK, 30'd0}},
        '{MODE_POLL, 30'd0,        30'd0,        1'b0, '{STATUS_OK, 30'd0}},
        // tie on priority, smaller id first
        '{MODE_SET,  30'd3,        30'd100,      1'b1, '{STATUS_OK, 30'd0}},
        '{MODE_POLL, 30'd0,        30'd0,        1'b0, '{STATUS_OK, 30'd0}},
        '{MODE_POLL, 30'd0,        30'd0,        1'b0, '{STATUS_OK, 30'd0}},
        '{MODE_SET,  30'd12345,    30'd0,        1'b1, '{STATUS_OK, 30'd0}},
        '{MODE_POLL, 30'd0,        30'd0,        1'b0, '{STATUS_OK, 30'd0}},
        '{MODE_POLL, 30'd0,        30'd0,        1'b0, '{STATUS_OK, 30'd0}},
        '{MODE_POLL, ID_MAX,       PRI_MAX,      1'b1, '{STATUS_EMPTY, 30'd0}},
        '{MODE_SET,  30'h2AAAAAAA, 30'h15555555, 1'b1, '{STATUS_OK, 30'd0}},
        '{MODE_SET,  30'h15555555, 30'h2AAAAAAA, 1'b1, '{STATUS_OK, 30'd0}},
        '{MODE_SET,  ID_MAX,       30'd0,        1'b1, '{STATUS_OK, 30'd0}},
        '{MODE_SET,  30'd0,        30'd0,        1'b1, '{STATUS_OK, 30'd0}},
        '{MODE_POLL, 30'h2AAAAAAA, 30'h15555555, 1'b0, '{STATUS_OK, 30'd0}},
        '{MODE_POLL, 30'h15555555, 30'h2AAAAAAA, 1'b0, '{STATUS_OK, 30'd0}},
        '{MODE_POLL, 30'd0,        30'd0,        1'b0, '{STATUS_OK, 30'd0}},
        '{MODE_POLL, 30'd0,        30'd0,        1'b0, '{STATUS_OK, 30'd0}},
        '{MODE_POLL, 30'd0,        30'd0,        1'b1, '{STATUS_EMPTY, 30'd0}}
    };

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_mode;
    logic [ID_W-1:0]     s_event_id;
    logic [PRI_W-1:0]    s_priority_req;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [ID_W-1:0]     m_polled_id;

    // predictor state: one slot per held event
    logic             held_valid [CAPACITY];
    logic [ID_W-1:0]  held_id    [CAPACITY];
    logic [PRI_W-1:0] held_pri   [CAPACITY];

    outcome_t pending_results[$];
    int       err_count = 0;
    int       send_idle_pct;
    int       recv_idle_pct;

    updatable_priority_event_queue dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_event_id     (s_event_id),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_polled_id    (m_polled_id)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic outcome_t predict_queue_op(input logic mode,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [PRI_W-1:0] pri);
        outcome_t res;
        int       free_slot;
        int       best;
        logic     hit;
        res       = '{STATUS_OK, '0};
        free_slot = -1;
        best      = -1;
        hit       = 1'b0;
        if (mode == MODE_SET) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (!hit && held_valid[i] && held_id[i] == id) begin
                    held_pri[i] = pri;
                    hit = 1'b1;
                end
                if (!held_valid[i] && free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (!hit) begin
                if (free_slot < 0) begin
                    res.status = STATUS_FULL;
                end else begin
                    held_valid[free_slot] = 1'b1;
                    held_id[free_slot]    = id;
                    held_pri[free_slot]   = pri;
                end
            end
        end else begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (held_valid[i] && (best < 0 || held_pri[i] > held_pri[best] ||
                        (held_pri[i] == held_pri[best] && held_id[i] < held_id[best]))) begin
                    best = i;
                end
            end
            if (best < 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.polled_id    = held_id[best];
                held_valid[best] = 1'b0;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_LIMIT) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // Called at a rising edge; returns at the edge that accepts the request.
    // valid is left high so a back-to-back request needs no second assignment.
    task automatic send_request(input logic mode, input logic [ID_W-1:0] id,
                                input logic [PRI_W-1:0] pri, input logic typed,
                                input outcome_t want);
        outcome_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_event_id     <= id;
        s_priority_req <= pri;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_queue_op(mode, id, pri);
        pending_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d id=%0d",
                                          m_status, m_polled_id));
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_status, want.status));
                end
                if (m_polled_id !== want.polled_id) begin
                    report_mismatch($sformatf("polled_id %0d, expected %0d",
                                              m_polled_id, want.polled_id));
                end
            end
        end
    end

    initial begin
        logic             mode;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        int               pick;
        int               drain_wait;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_mode         = MODE_SET;
        s_event_id     = '0;
        s_priority_req = '0;
        send_idle_pct  = 27;
        recv_idle_pct  = 50;
        for (int i = 0; i < CAPACITY; i++) begin
            held_valid[i] = 1'b0;
            held_id[i]    = '0;
            held_pri[i]   = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[r]) begin
            send_request(DIR_ROWS[r].mode, DIR_ROWS[r].id, DIR_ROWS[r].pri,
                         DIR_ROWS[r].typed, DIR_ROWS[r].want);
        end

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 50;
                recv_idle_pct = 27;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                // mostly sets for the first FILL_LEN requests of a phase, then mostly polls
                if (k < FILL_LEN) begin
                    mode = ($urandom_range(0, 99) < 5) ? MODE_POLL : MODE_SET;
                end else begin
                    mode = ($urandom_range(0, 99) < 90) ? MODE_POLL : MODE_SET;
                end
                pick = $urandom_range(0, 19);
                if (pick < 4) begin
                    id = ID_W'($urandom_range(0, 31));     // small pool: updates of held ids
                end else if (pick == 4) begin
                    id = $urandom_range(0, 1) ? ID_MAX : '0;
                end else begin
                    id = ID_W'($urandom);
                end
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    pri = PRI_W'($urandom_range(0, 7));     // frequent ties
                end else if (pick == 3) begin
                    case ($urandom_range(0, 3))
                        0: pri = '0;
                        1: pri = PRI_BILLION;
                        2: pri = PRI_BILLION + 30'd1;
                        default: pri = PRI_MAX;
                    endcase
                end else begin
                    pri = PRI_W'($urandom);
                end
                send_request(mode, id, pri, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end

        if (err_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
